/* hdl/thc_pkg.sv */
// shared types and constants for the temperature and humidity compensation core
`default_nettype none
package thc_pkg;

  localparam int unsigned OpW = 64;

  typedef enum logic [2:0] {
    SH_0,
    SH_2,
    SH_6,
    SH_16,
    SH_19,
    SH_24
  } thc_shift_e;

  typedef struct packed {
    logic       start;
    thc_shift_e sh;
  } thc_mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } thc_mul_stat_t;

endpackage
`default_nettype wire

/* hdl/thc_mul.sv */
// bit-serial signed multiplier with truncating shift and saturation
`default_nettype none
module thc_mul import thc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  thc_mul_req_t          req_i,
  input  logic signed [OpW-1:0] a_i,
  input  logic signed [OpW-1:0] b_i,
  output thc_mul_stat_t         stat_o,
  output logic signed [OpW-1:0] p_o
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_SAT
  } mstate_e;

  mstate_e            state_q;
  logic [5:0]         cnt_q;
  logic               done_q;
  logic [OpW-1:0]     hi_q, lo_q, ua_q;
  logic               neg_q;
  thc_shift_e         sh_q;
  logic signed [OpW-1:0] p_q;

  logic [OpW:0]       sum;
  logic [2*OpW-1:0]   prod, shifted;
  logic [OpW-1:0]     mag_a, mag_b, mag_r;
  logic signed [OpW-1:0] sat_res;

  assign mag_a = a_i[OpW-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[OpW-1] ? (~b_i + 1'b1) : b_i;
  assign sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, ua_q} : '0);
  assign prod  = {hi_q, lo_q};

  always_comb begin
    unique case (sh_q)
      SH_0:    shifted = prod;
      SH_2:    shifted = prod >> 2;
      SH_6:    shifted = prod >> 6;
      SH_16:   shifted = prod >> 16;
      SH_19:   shifted = prod >> 19;
      SH_24:   shifted = prod >> 24;
      default: shifted = prod;
    endcase
    if (shifted[2*OpW-1:OpW-1] != '0) begin
      mag_r = {1'b0, {(OpW-1){1'b1}}};
    end else begin
      mag_r = shifted[OpW-1:0];
    end
    sat_res = neg_q ? $signed(~mag_r + 1'b1) : $signed(mag_r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            cnt_q   <= '0;
            state_q <= M_RUN;
          end
        end
        M_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '1) begin
            state_q <= M_SAT;
          end
        end
        M_SAT: begin
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && req_i.start) begin
      ua_q  <= mag_a;
      lo_q  <= mag_b;
      hi_q  <= '0;
      neg_q <= a_i[OpW-1] ^ b_i[OpW-1];
      sh_q  <= req_i.sh;
    end else if (state_q == M_RUN) begin
      hi_q <= sum[OpW:1];
      lo_q <= {sum[0], lo_q[OpW-1:1]};
    end else if (state_q == M_SAT) begin
      p_q <= sat_res;
    end
  end

  assign stat_o.busy = (state_q != M_IDLE);
  assign stat_o.done = done_q;
  assign p_o         = p_q;

endmodule
`default_nettype wire

/* hdl/temp_humidity_compensation_core.sv */
// top level of the temperature and humidity compensation core
//
//   channel | direction | signals
//   in      | in        | in_valid_i, in_ready_o, op_i, raw_sample_i
//   out     | out       | out_valid_o, out_ready_i, reading_o
//   cfg     | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// temperature item: up to 5 multiplies (the last is skipped when the fine value is not positive),
// humidity item: 6 multiplies; a zero sample uses no multiply
// each multiply runs on one bit-serial 64x64 unit, one multiplier bit per cycle
// reset restores the calibration defaults and clears fine temperature
// a result waits in the output register; the next item is taken once it is loaded
`default_nettype none
module temp_humidity_compensation_core import thc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [15:0] raw_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] reading_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [2:0] {
    CFG_T1, CFG_T2, CFG_T3, CFG_H1, CFG_H2, CFG_H4, CFG_H5, CFG_H6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    T_VAR1, T_DSQ, T_VAR2, T_FINE, T_DIV,
    H_A, H_B, H_T, H_H, H_U, H_F
  } step_e;

  localparam logic signed [OpW-1:0] QOne     = 64'sd16777216;
  localparam logic signed [OpW-1:0] HumMax   = 64'sd1677721600;
  localparam logic signed [OpW-1:0] FineOfs  = 64'sd4800;
  localparam logic signed [OpW-1:0] RecipFive = 64'sd13108;
  localparam logic signed [OpW-1:0] MulOne   = 64'sd1;

  state_e      state_q;
  step_e       step_q;
  logic        op_q;
  logic [15:0] raw_q;
  logic [15:0] res_q;
  logic [15:0] reading_q;
  logic        out_valid_q;
  logic signed [31:0]    fine_q;
  logic signed [OpW-1:0] acc_q, tmp_q;

  logic [15:0] cal_t1_q, cal_t2_q, cal_t3_q, cal_h2_q;
  logic [7:0]  cal_h1_q, cal_h6_q;
  logic [11:0] cal_h4_q, cal_h5_q;

  thc_mul_req_t          mul_req;
  thc_mul_stat_t         mul_stat;
  logic signed [OpW-1:0] mul_a, mul_b, mul_res;
  logic signed [OpW-1:0] d64, v1_64, raw64, h4_64;
  logic                  out_load;

  assign d64   = {48'd0, raw_q} - {48'd0, cal_t1_q};
  assign v1_64 = {{32{fine_q[31]}}, fine_q} - FineOfs;
  assign raw64 = {24'd0, raw_q, 24'd0};
  assign h4_64 = {{52{cal_h4_q[11]}}, cal_h4_q};

  always_comb begin
    mul_req.start = (state_q == ST_ISSUE);
    mul_a      = d64;
    mul_b      = d64;
    mul_req.sh = SH_0;
    unique case (step_q)
      T_VAR1: mul_b = {{48{cal_t2_q[15]}}, cal_t2_q};
      T_DSQ:  mul_b = d64;
      T_VAR2: begin
        mul_a = tmp_q;
        mul_b = {{48{cal_t3_q[15]}}, cal_t3_q};
        mul_req.sh = SH_6;
      end
      T_FINE: begin
        mul_a = acc_q;
        mul_b = MulOne;
        mul_req.sh = SH_24;
      end
      T_DIV: begin
        mul_a = tmp_q;
        mul_b = RecipFive;
        mul_req.sh = SH_16;
      end
      H_A: begin
        mul_a = {{52{cal_h5_q[11]}}, cal_h5_q};
        mul_b = v1_64;
      end
      H_B: begin
        mul_a = {{56{cal_h6_q[7]}}, cal_h6_q};
        mul_b = v1_64;
        mul_req.sh = SH_2;
      end
      H_T: begin
        mul_a = acc_q;
        mul_b = {{48{cal_h2_q[15]}}, cal_h2_q};
        mul_req.sh = SH_16;
      end
      H_H: begin
        mul_a = acc_q;
        mul_b = tmp_q;
        mul_req.sh = SH_24;
      end
      H_U: begin
        mul_a = {56'd0, cal_h1_q};
        mul_b = acc_q;
        mul_req.sh = SH_19;
      end
      H_F: begin
        mul_a = acc_q;
        mul_b = tmp_q;
        mul_req.sh = SH_24;
      end
      default: mul_req.sh = SH_0;
    endcase
  end

  thc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .p_o    (mul_res)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t1_q <= 16'd28326;
      cal_t2_q <= 16'd26604;
      cal_t3_q <= 16'd12850;
      cal_h1_q <= 8'd75;
      cal_h2_q <= 16'd383;
      cal_h4_q <= 12'd271;
      cal_h5_q <= 12'd50;
      cal_h6_q <= 8'd30;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_T1: cal_t1_q <= cfg_data_i;
        CFG_T2: cal_t2_q <= cfg_data_i;
        CFG_T3: cal_t3_q <= cfg_data_i;
        CFG_H1: cal_h1_q <= cfg_data_i[7:0];
        CFG_H2: cal_h2_q <= cfg_data_i;
        CFG_H4: cal_h4_q <= cfg_data_i[11:0];
        CFG_H5: cal_h5_q <= cfg_data_i[11:0];
        CFG_H6: cal_h6_q <= cfg_data_i[7:0];
        default: cal_t1_q <= cal_t1_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= T_VAR1;
      op_q        <= 1'b0;
      raw_q       <= '0;
      res_q       <= '0;
      reading_q   <= '0;
      out_valid_q <= 1'b0;
      fine_q      <= '0;
      acc_q       <= '0;
      tmp_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q  <= op_i;
            raw_q <= raw_sample_i;
            res_q <= '0;
            if (raw_sample_i == '0) begin
              state_q <= ST_DONE;
            end else begin
              step_q  <= op_i ? H_A : T_VAR1;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (mul_stat.done) begin
            unique case (step_q)
              T_VAR1: begin
                acc_q   <= mul_res <<< 10;
                step_q  <= T_DSQ;
                state_q <= ST_ISSUE;
              end
              T_DSQ: begin
                tmp_q   <= mul_res;
                step_q  <= T_VAR2;
                state_q <= ST_ISSUE;
              end
              T_VAR2: begin
                acc_q   <= acc_q + mul_res;
                step_q  <= T_FINE;
                state_q <= ST_ISSUE;
              end
              T_FINE: begin
                fine_q <= mul_res[31:0];
                tmp_q  <= mul_res >>> 6;
                step_q <= T_DIV;
                if (mul_res[OpW-1] || mul_res == '0) begin
                  state_q <= ST_DONE;
                end else begin
                  state_q <= ST_ISSUE;
                end
              end
              T_DIV: begin
                res_q   <= mul_res[15:0];
                state_q <= ST_DONE;
              end
              H_A: begin
                acc_q   <= raw64 - (h4_64 <<< 30) - (mul_res <<< 10);
                step_q  <= H_B;
                state_q <= ST_ISSUE;
              end
              H_B: begin
                tmp_q   <= QOne + mul_res;
                step_q  <= H_T;
                state_q <= ST_ISSUE;
              end
              H_T: begin
                acc_q   <= mul_res;
                step_q  <= H_H;
                state_q <= ST_ISSUE;
              end
              H_H: begin
                acc_q   <= mul_res;
                step_q  <= H_U;
                state_q <= ST_ISSUE;
              end
              H_U: begin
                tmp_q   <= QOne - mul_res;
                step_q  <= H_F;
                state_q <= ST_ISSUE;
              end
              H_F: begin
                priority if (mul_res[OpW-1]) begin
                  res_q <= '0;
                end else if (mul_res > HumMax) begin
                  res_q <= 16'd100;
                end else begin
                  res_q <= mul_res[39:24];
                end
                state_q <= ST_DONE;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_DONE: begin
          if (out_load) begin
            reading_q   <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign reading_o   = reading_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_stat.busy)
    else $error("multiply started while busy");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mul_stat.busy)
    else $error("multiplier busy while taking an item");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && op_q |=> reading_o <= 16'd100)
    else $error("humidity out of range");

  a_zero_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && raw_q == '0 |=> reading_o == '0)
    else $error("zero sample gave nonzero reading");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// testbench for the temperature and humidity compensation core, checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import thc_pkg::*;

  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_HUM  = 1'b1;
  localparam logic [2:0] REG_T1 = 3'd0, REG_T2 = 3'd1, REG_T3 = 3'd2, REG_H1 = 3'd3;
  localparam logic [2:0] REG_H2 = 3'd4, REG_H4 = 3'd5, REG_H5 = 3'd6, REG_H6 = 3'd7;
  localparam int MODE_NONE = 0, MODE_SEND = 1, MODE_RECV = 2, MODE_BOTH = 3;
  localparam longint Q_ONE = 64'sd1 << 24;
  localparam int CYCLE_LIMIT = 3000000;

  class thc_scoreboard;
    longint t1, t2, t3, h1, h2, h4, h5, h6;
    int fine_temp;
    logic [15:0] pending_readings[$];
    int errors;
    int checked;

    function new();
      t1 = 28326; t2 = 26604; t3 = 12850; h1 = 75;
      h2 = 383; h4 = 271; h5 = 50; h6 = 30;
      fine_temp = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_T1: t1 = longint'(data);
        REG_T2: t2 = longint'($signed(data));
        REG_T3: t3 = longint'($signed(data));
        REG_H1: h1 = longint'(data[7:0]);
        REG_H2: h2 = longint'($signed(data));
        REG_H4: h4 = longint'($signed(data[11:0]));
        REG_H5: h5 = longint'($signed(data[11:0]));
        REG_H6: h6 = longint'($signed(data[7:0]));
        default: ;
      endcase
    endfunction

    // truncating fixed-point product, saturated to the signed 64-bit range
    function longint scaled_product(longint a, longint b, int sh);
      logic [127:0] ua, ub, p, q;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? 128'd0 - {{64{a[63]}}, a} : {64'd0, a};
      ub = b < 0 ? 128'd0 - {{64{b[63]}}, b} : {64'd0, b};
      p = ua * ub;
      q = p >> sh;
      if (q > 128'h7fffffffffffffff) return neg ? -64'sh7fffffffffffffff : 64'sh7fffffffffffffff;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function logic [15:0] compensate_temp(logic [15:0] raw);
      longint d, var1, var2, sum, t;
      d = longint'(raw) - t1;
      var1 = d * t2 * 1024;
      var2 = (d * d * t3) / 64;
      sum = var1 + var2;
      t = sum / (320 * Q_ONE);
      fine_temp = int'(sum / Q_ONE);
      if (t < 0) return 16'd0;
      if (t > 65535) return 16'hffff;
      return t[15:0];
    endfunction

    function logic [15:0] compensate_hum(logic [15:0] raw);
      longint v1, offs, x, g, t, hh, u, h;
      v1 = longint'(fine_temp) - 4800;
      offs = h4 * (64'sd1 << 30) + h5 * v1 * 1024;
      x = longint'(raw) * Q_ONE - offs;
      g = Q_ONE + (h6 * v1) / 4;
      t = scaled_product(x, h2, 16);
      hh = scaled_product(t, g, 24);
      u = scaled_product(h1, hh, 19);
      h = scaled_product(hh, Q_ONE - u, 24);
      if (h > 100 * Q_ONE) return 16'd100;
      if (h < 0) return 16'd0;
      return 16'(h / Q_ONE);
    endfunction

    function void note_sample(logic op, logic [15:0] raw);
      logic [15:0] r;
      if (raw == 16'd0) r = 16'd0;
      else if (op == OP_TEMP) r = compensate_temp(raw);
      else r = compensate_hum(raw);
      pending_readings.push_back(r);
    endfunction

    function void check_reading(logic [15:0] actual);
      logic [15:0] want;
      checked++;
      if (pending_readings.size() == 0) begin
        $error("reading: unexpected item, actual %0d", actual);
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      if (actual !== want) begin
        $error("reading: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = OP_TEMP;
  logic [15:0] raw_sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] reading_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  thc_scoreboard sb = new();
  int mode = MODE_NONE;
  int cycles = 0;
  int n_items = 0;

  temp_humidity_compensation_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_reading(reading_o);
    if (mode == MODE_RECV) out_ready_i <= $urandom_range(99) >= 83;
    else if (mode == MODE_BOTH) out_ready_i <= $urandom_range(99) >= 22;
    else out_ready_i <= 1'b1;
  end

  task automatic send_sample(logic op, logic [15:0] raw);
    int idle;
    if (mode == MODE_SEND) idle = $urandom_range(99) < 83 ? $urandom_range(1, 8) : 0;
    else if (mode == MODE_BOTH) idle = $urandom_range(99) < 22 ? $urandom_range(1, 8) : 0;
    else idle = 0;
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    raw_sample_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_sample(op, raw);
    n_items++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_readings.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] t1, logic [15:0] t2, logic [15:0] t3,
                           logic [15:0] h1, logic [15:0] h2, logic [15:0] h4,
                           logic [15:0] h5, logic [15:0] h6);
    write_reg(REG_T1, t1); write_reg(REG_T2, t2); write_reg(REG_T3, t3);
    write_reg(REG_H1, h1); write_reg(REG_H2, h2); write_reg(REG_H4, h4);
    write_reg(REG_H5, h5); write_reg(REG_H6, h6);
  endtask

  // mostly temperature then humidity pairs, with single humidity, noise and zero samples mixed in
  task automatic random_samples(int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0: send_sample(1'($urandom), 16'd0);
        1: send_sample(1'($urandom), 16'($urandom));
        2: send_sample(OP_HUM, 16'($urandom_range(1, 65535)));
        default: begin
          send_sample(OP_TEMP, 16'($urandom_range(1, 65535)));
          send_sample(OP_HUM, 16'($urandom_range(1, 65535)));
          k++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples at reset calibration
    send_sample(OP_HUM, 16'd30000);
    send_sample(OP_TEMP, 16'd0);
    send_sample(OP_HUM, 16'd0);
    send_sample(OP_TEMP, 16'd28326);
    send_sample(OP_TEMP, 16'd1);
    send_sample(OP_HUM, 16'd1);
    send_sample(OP_HUM, 16'hffff);
    send_sample(OP_TEMP, 16'hffff);
    send_sample(OP_HUM, 16'hffff);
    send_sample(OP_HUM, 16'd1);
    send_sample(OP_TEMP, 16'd0);
    send_sample(OP_HUM, 16'd26000);
    send_sample(OP_TEMP, 16'd32000);
    send_sample(OP_HUM, 16'd28000);
    send_sample(OP_TEMP, 16'd20000);
    send_sample(OP_HUM, 16'd40000);
    drain();

    mode = MODE_NONE;
    random_samples(100);
    drain();

    // all coefficients at their upper extremes
    write_all(16'hffff, 16'h7fff, 16'h7fff, 16'hffff, 16'h7fff, 16'h07ff, 16'h07ff, 16'h007f);
    mode = MODE_SEND;
    random_samples(100);
    drain();

    // all coefficients at their lower extremes
    write_all(16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'h8000, 16'hf800, 16'hf800, 16'hff80);
    mode = MODE_RECV;
    random_samples(100);
    drain();

    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    mode = MODE_BOTH;
    random_samples(100);
    drain();

    write_all(16'd28326, 16'd26604, 16'd12850, 16'd75, 16'd383, 16'd271, 16'd50, 16'd30);
    mode = MODE_SEND;
    random_samples(90);
    mode = MODE_NONE;
    random_samples(90);
    drain();
    repeat (100) @(posedge clk_i);

    $display("tb_top: %0d samples sent, %0d readings checked, over five calibration sets",
             n_items, sb.checked);
    $display("tb_top: covered zero samples, extreme raw values and idle/stall mixes");
    if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hdl/thc_pkg.sv
hdl/thc_mul.sv
hdl/temp_humidity_compensation_core.sv
tb/tb_top.sv
